FILE: rtl/binary_2x2_opening_cover_check_unit_defines.svh
// Assertion shorthands shared by the checker.
`ifndef BINARY_2X2_OPENING_COVER_CHECK_UNIT_DEFINES_SVH
`define BINARY_2X2_OPENING_COVER_CHECK_UNIT_DEFINES_SVH

// same-cycle implication, reset masks the check
`define BOCC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define BOCC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/bocc_pkg.sv
`default_nettype none

package bocc_pkg;

	localparam int MAX_DIM = 64;
	localparam int COL_W   = $clog2(MAX_DIM);

	// fixed field widths
	localparam int DIM_W   = 7;
	localparam int CNT_W   = 12;

	// queue between front and back
	localparam int QDEPTH  = 4;
	localparam int QPTR_W  = $clog2(QDEPTH);
	localparam int QCNT_W  = $clog2(QDEPTH + 1);

	// configuration port
	localparam int CFG_IDX_W = 8;
	localparam logic [CFG_IDX_W-1:0] REG_ROWS = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COLS = 8'd1;

	typedef struct packed {
		logic [DIM_W-1:0] rows;
		logic [DIM_W-1:0] cols;
	} bocc_dims_t;

	// one queue entry: everything a single pixel produced
	typedef struct packed {
		logic             win;
		logic [DIM_W-1:0] top_row;
		logic [DIM_W-1:0] left_col;
		logic             summ;
		logic [CNT_W-1:0] count;
		logic             all_cov;
	} bocc_evt_t;

	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
		logic [DIM_W-1:0] r;
		if (v == '0)
			r = DIM_W'(1);
		else if (v > DIM_W'(MAX_DIM))
			r = DIM_W'(MAX_DIM);
		else
			r = v;
		return r;
	endfunction

endpackage

`default_nettype wire

FILE: rtl/bocc_front.sv
`default_nettype none

module bocc_front
	import bocc_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       accept,
	input  wire logic       pixel,
	input  wire bocc_dims_t dims,
	output logic            push,
	output bocc_evt_t       evt
);

	logic [MAX_DIM-1:0] upper_pix_q, cur_pix_q, upper_cov_q, cur_cov_q;
	logic [DIM_W-1:0]   row_q, col_q;
	logic [CNT_W-1:0]   count_q;
	logic               unc_q;

	logic [COL_W-1:0]   c_idx, cm1;
	logic [MAX_DIM-1:0] cur_pix_n, two, used, cur_cov_w, upper_cov_w;
	logic               win, row_end, img_end, upper_unc, cur_unc, unc_w;
	logic [CNT_W-1:0]   count_w;

	assign c_idx = col_q[COL_W-1:0];
	assign cm1   = c_idx - COL_W'(1);

	always_comb begin
		for (int i = 0; i < MAX_DIM; i++) begin
			cur_pix_n[i] = (COL_W'(i) == c_idx) ? pixel : cur_pix_q[i];
			two[i]       = (COL_W'(i) == c_idx) || (COL_W'(i) == cm1);
			used[i]      = 8'(i) < {1'b0, dims.cols};
		end
	end

	// bottom-right corner of an all-ones 2x2 window
	assign win = (row_q != '0) && (col_q != '0) && pixel && cur_pix_q[cm1]
		&& upper_pix_q[c_idx] && upper_pix_q[cm1];

	assign cur_cov_w   = cur_cov_q   | (win ? two : '0);
	assign upper_cov_w = upper_cov_q | (win ? two : '0);
	assign count_w     = count_q + CNT_W'(win);

	assign row_end = ({1'b0, col_q} + 8'd1) >= {1'b0, dims.cols};
	assign img_end = row_end && (({1'b0, row_q} + 8'd1) >= {1'b0, dims.rows});

	// upper row is final once the current row closes
	assign upper_unc = |(upper_pix_q & ~upper_cov_w & used);
	assign cur_unc   = |(cur_pix_n & ~cur_cov_w & used);
	assign unc_w     = unc_q | (row_end & upper_unc) | (img_end & cur_unc);

	assign push = accept && (win || img_end);

	always_comb begin
		evt.win      = win;
		evt.top_row  = row_q;
		evt.left_col = col_q;
		evt.summ     = img_end;
		evt.count    = count_w;
		evt.all_cov  = !unc_w;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upper_pix_q <= '0;
			cur_pix_q   <= '0;
			upper_cov_q <= '0;
			cur_cov_q   <= '0;
			row_q       <= '0;
			col_q       <= '0;
			count_q     <= '0;
			unc_q       <= 1'b0;
		end else if (accept) begin
			priority if (img_end) begin
				upper_pix_q <= '0;
				cur_pix_q   <= '0;
				upper_cov_q <= '0;
				cur_cov_q   <= '0;
				row_q       <= '0;
				col_q       <= '0;
				count_q     <= '0;
				unc_q       <= 1'b0;
			end else if (row_end) begin
				upper_pix_q <= cur_pix_n;
				upper_cov_q <= cur_cov_w;
				cur_pix_q   <= '0;
				cur_cov_q   <= '0;
				row_q       <= row_q + DIM_W'(1);
				col_q       <= '0;
				count_q     <= count_w;
				unc_q       <= unc_w;
			end else begin
				cur_pix_q   <= cur_pix_n;
				cur_cov_q   <= cur_cov_w;
				upper_cov_q <= upper_cov_w;
				col_q       <= col_q + DIM_W'(1);
				count_q     <= count_w;
				unc_q       <= unc_w;
			end
		end
	end

endmodule

`default_nettype wire

FILE: rtl/bocc_fifo.sv
`default_nettype none

module bocc_fifo
	import bocc_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      push,
	input  wire bocc_evt_t wr_evt,
	input  wire logic      pop,
	output bocc_evt_t      head,
	output logic           empty,
	output logic           full
);

	bocc_evt_t         mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;

	assign empty = (cnt_q == '0);
	assign full  = (cnt_q == QCNT_W'(QDEPTH));
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= wr_evt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			if (pop)
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + QCNT_W'(1);
				2'b01:   cnt_q <= cnt_q - QCNT_W'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

`default_nettype wire

FILE: rtl/bocc_back.sv
`default_nettype none

module bocc_back
	import bocc_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire bocc_evt_t   head,
	input  wire logic        empty,
	output logic             pop,
	output logic             res_valid,
	input  wire logic        res_stall,
	output logic             kind,
	output logic [DIM_W-1:0] top_row,
	output logic [DIM_W-1:0] left_col,
	output logic [CNT_W-1:0] window_count,
	output logic             all_covered,
	output logic             last
);

	logic win_sent_q;
	logic show_win, beat;

	// an entry with both a window and the summary takes two beats
	assign show_win  = head.win && !win_sent_q;
	assign res_valid = !empty;
	assign beat      = res_valid && !res_stall;
	assign pop       = beat && !(show_win && head.summ);

	assign kind         = !show_win;
	assign last         = !show_win;
	assign top_row      = show_win ? head.top_row  : '0;
	assign left_col     = show_win ? head.left_col : '0;
	assign window_count = show_win ? '0 : head.count;
	assign all_covered  = show_win ? 1'b0 : head.all_cov;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			win_sent_q <= 1'b0;
		else if (beat)
			win_sent_q <= !pop;
	end

endmodule

`default_nettype wire

FILE: rtl/binary_2x2_opening_cover_check_unit.sv
// 2x2 opening cover check over a binary image streamed in row-major order.
// Pixel channel: pix_valid / pix_stall with one bit, pixel, per beat.
// Result channel: res_valid / res_stall; a window beat (kind 0) gives the
//   1-based top-left corner, the summary beat (kind 1, last 1) closes the image
//   with the window count and all_covered.
// Config channel: cfg_valid / cfg_ready (always ready), cfg_index 0 = rows,
//   1 = cols; other indexes are ignored. Write only while the block is idle.
// Throughput: one pixel per cycle while pix_stall is low. The front holds all
//   per-image state and decides each pixel against the two row buffers; the back
//   needs two beats only for a final pixel that also closes a window.
// A result is registered in the queue before it is offered on the result channel.
// Stalling: results wait in a four-entry queue; pix_stall rises only once
//   the queue is full, so the source keeps streaming through short stalls.
// Reset: rows and cols return to 64, the image position, row buffers, count
//   and queue are cleared. After the final pixel of an image the next pixel starts
//   a new image at row 1, column 1.
`default_nettype none

module binary_2x2_opening_cover_check_unit
	import bocc_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	// pixel stream
	input  wire logic                 pix_valid,
	output logic                      pix_stall,
	input  wire logic                 pixel,
	// results
	output logic                      res_valid,
	input  wire logic                 res_stall,
	output logic                      kind,
	output logic [DIM_W-1:0]          top_row,
	output logic [DIM_W-1:0]          left_col,
	output logic [CNT_W-1:0]          window_count,
	output logic                      all_covered,
	output logic                      last,
	// configuration writes
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [DIM_W-1:0]     cfg_data
);

	logic [DIM_W-1:0] rows_q, cols_q;
	bocc_dims_t       dims;
	logic             accept, push, pop, q_empty, q_full;
	bocc_evt_t        wr_evt, head;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= DIM_W'(MAX_DIM);
			cols_q <= DIM_W'(MAX_DIM);
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == REG_ROWS)
				rows_q <= cfg_data;
			if (cfg_index == REG_COLS)
				cols_q <= cfg_data;
		end
	end

	// zero reads as one, anything past the buffer size as the buffer size
	always_comb begin
		dims.rows = clamp_dim(rows_q);
		dims.cols = clamp_dim(cols_q);
	end

	assign pix_stall = q_full;
	assign accept    = pix_valid && !pix_stall;

	bocc_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.pixel  (pixel),
		.dims   (dims),
		.push   (push),
		.evt    (wr_evt)
	);

	bocc_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_evt (wr_evt),
		.pop    (pop),
		.head   (head),
		.empty  (q_empty),
		.full   (q_full)
	);

	bocc_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.empty        (q_empty),
		.pop          (pop),
		.res_valid    (res_valid),
		.res_stall    (res_stall),
		.kind         (kind),
		.top_row      (top_row),
		.left_col     (left_col),
		.window_count (window_count),
		.all_covered  (all_covered),
		.last         (last)
	);

endmodule

`default_nettype wire

FILE: rtl/bocc_checker.sv
`default_nettype none
`include "binary_2x2_opening_cover_check_unit_defines.svh"

module bocc_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        res_valid,
	input wire logic        res_stall,
	input wire logic        kind,
	input wire logic [6:0]  top_row,
	input wire logic [6:0]  left_col,
	input wire logic [11:0] window_count,
	input wire logic        all_covered,
	input wire logic        last
);

	`BOCC_ASSERT_NEXT(a_res_hold, res_valid && res_stall, res_valid && $stable(kind) && $stable(top_row) && $stable(left_col) && $stable(window_count), "result beat changed under stall")
	`BOCC_ASSERT_NOW(a_last_kind, res_valid, kind == last, "last and kind disagree")
	`BOCC_ASSERT_NOW(a_win_beat, res_valid && !kind, top_row != 7'd0 && left_col != 7'd0 && window_count == 12'd0 && !all_covered, "malformed window beat")
	`BOCC_ASSERT_NOW(a_sum_beat, res_valid && kind, top_row == 7'd0 && left_col == 7'd0, "summary beat carries a corner")

endmodule

bind binary_2x2_opening_cover_check_unit bocc_checker u_bocc_checker (.*);

`default_nettype wire
